[rtl/core/atl_pkg.sv]
`default_nettype none

package atl_pkg;

  // token kinds as they appear on the result word
  typedef enum logic [3:0] {
    TK_PLUS    = 4'd0,
    TK_MINUS   = 4'd1,
    TK_STAR    = 4'd2,
    TK_SLASH   = 4'd3,
    TK_EQUAL   = 4'd4,
    TK_EQEQ    = 4'd5,
    TK_INT     = 4'd6,
    TK_UNKNOWN = 4'd7,
    TK_EOF     = 4'd8
  } tok_kind_t;

  // what is held back waiting for the next byte
  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_EQ    = 2'd1,
    MODE_INT   = 2'd2,
    MODE_SPARE = 2'd3
  } pend_mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    tok_kind_t   kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
  } tok_t;

endpackage

`default_nettype wire

[rtl/core/atl_if.sv]
`default_nettype none

interface atl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_source;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_source, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_source, output ready);
endinterface

interface atl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output line_number, output column_number,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input line_number, input column_number,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/core/arith_token_lexer_core.sv]
`default_nettype none

// arith_token_lexer_core: byte-serial lexer for a small arithmetic language
//
// in_chan carries one source byte per word (byte_present) plus an
// end_of_source flag; a word with both flags low does nothing. out_chan
// carries one token per word: kind, start offset, length, line, column, and
// last_of_run on the final token that an input word produced.
// a word accepted into the input register is lexed into the result buffer
// once that buffer is free, and its first token is then on out_chan.
// throughput: one input word per cycle while every word yields at most one
// token and out_chan is ready; a word that yields n tokens (n up to three)
// holds the result buffer until all are taken, so the output port sets the rate.
// a stalled receiver holds the current token; one more input word is taken
// into the input register and waits there, then in_chan.ready drops.
// reset (rst_n low, synchronous) empties both stages and returns position to
// 0, line and column to 1 and drops any pending token; no clearing pass.
// after an end_of_source word the counters go back to their reset values so
// a new source can follow at once.
module arith_token_lexer_core #(
  parameter int POS_WIDTH = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  atl_in_if.sink     in_chan,
  atl_out_if.source  out_chan
);
  import atl_pkg::*;

  localparam int ExtW = (POS_WIDTH > 16) ? POS_WIDTH : 16;
  localparam logic [POS_WIDTH-1:0] PosMax = {POS_WIDTH{1'b1}};

  // input register stage
  logic       inq_v_r;
  logic [7:0] inq_byte_r;
  logic       inq_present_r;
  logic       inq_end_r;

  // lexer state
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [15:0]          line_r, line_nxt;
  logic [15:0]          col_r, col_nxt;
  pend_mode_t           mode_r, mode_nxt;
  logic [POS_WIDTH-1:0] pstart_r, pstart_nxt;
  logic [15:0]          pcol_r, pcol_nxt;

  // result buffer, up to three tokens per input word
  tok_t       res_r [3];
  tok_t       res_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] rd_r;

  logic pop, buf_free, move;

  // token start and length carry the low 16 bits of the position
  function automatic tok_t mk_tok(input tok_kind_t k, input logic [POS_WIDTH-1:0] s,
                                  input logic [POS_WIDTH-1:0] len,
                                  input logic [15:0] ln, input logic [15:0] cl);
    logic [ExtW-1:0] s_ext;
    logic [ExtW-1:0] l_ext;
    tok_t t;
    s_ext   = ExtW'(s);
    l_ext   = ExtW'(len);
    t.kind  = k;
    t.start = s_ext[15:0];
    t.len   = l_ext[15:0];
    t.line  = ln;
    t.col   = cl;
    return t;
  endfunction

  // handshakes
  assign pop            = (cnt_r != 2'd0) && out_chan.ready;
  assign buf_free       = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_chan.ready);
  assign move           = inq_v_r && buf_free;
  assign in_chan.ready  = !inq_v_r || move;

  // output word
  assign out_chan.valid         = (cnt_r != 2'd0);
  assign out_chan.token_kind    = res_r[rd_r].kind;
  assign out_chan.start_offset  = res_r[rd_r].start;
  assign out_chan.token_length  = res_r[rd_r].len;
  assign out_chan.line_number   = res_r[rd_r].line;
  assign out_chan.column_number = res_r[rd_r].col;
  assign out_chan.last_of_run   = (cnt_r == 2'd1);

  // lexing of the word in the input register against the current state
  always_comb begin
    logic is_digit;
    logic consumed;
    tok_kind_t k;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    mode_nxt   = ((mode_r == MODE_EQ) || (mode_r == MODE_INT)) ? mode_r : MODE_NONE;
    pstart_nxt = pstart_r;
    pcol_nxt   = pcol_r;
    cnt_nxt    = 2'd0;
    res_nxt[0] = '0;
    res_nxt[1] = '0;
    res_nxt[2] = '0;
    is_digit   = (inq_byte_r >= CH_ZERO) && (inq_byte_r <= CH_NINE);
    consumed   = 1'b0;
    k          = TK_UNKNOWN;

    if (inq_present_r) begin
      if ((mode_nxt == MODE_EQ) && (inq_byte_r == CH_EQ)) begin
        res_nxt[cnt_nxt] = mk_tok(TK_EQEQ, pstart_nxt, POS_WIDTH'(2), line_nxt, pcol_nxt);
        cnt_nxt  = cnt_nxt + 2'd1;
        mode_nxt = MODE_NONE;
        consumed = 1'b1;
      end else if ((mode_nxt == MODE_INT) && is_digit) begin
        consumed = 1'b1;
      end else begin
        // a pending token ends before this byte
        if (mode_nxt == MODE_EQ) begin
          res_nxt[cnt_nxt] = mk_tok(TK_EQUAL, pstart_nxt, POS_WIDTH'(1), line_nxt,
                                    pcol_nxt);
          cnt_nxt = cnt_nxt + 2'd1;
        end else if (mode_nxt == MODE_INT) begin
          res_nxt[cnt_nxt] = mk_tok(TK_INT, pstart_nxt, pos_nxt - pstart_nxt, line_nxt,
                                    pcol_nxt);
          cnt_nxt = cnt_nxt + 2'd1;
        end
        mode_nxt = MODE_NONE;
      end

      if (consumed) begin
        if (pos_nxt != PosMax) pos_nxt = pos_nxt + POS_WIDTH'(1);
        if (col_nxt != CNT_MAX) col_nxt = col_nxt + 16'd1;
      end else if (inq_byte_r == CH_NL) begin
        if (pos_nxt != PosMax) pos_nxt = pos_nxt + POS_WIDTH'(1);
        if (line_nxt != CNT_MAX) line_nxt = line_nxt + 16'd1;
        col_nxt = 16'd1;
      end else if ((inq_byte_r == CH_SPACE) || (inq_byte_r == CH_TAB) ||
                   (inq_byte_r == CH_NUL)) begin
        if (pos_nxt != PosMax) pos_nxt = pos_nxt + POS_WIDTH'(1);
        if (col_nxt != CNT_MAX) col_nxt = col_nxt + 16'd1;
      end else if ((inq_byte_r == CH_EQ) || is_digit) begin
        mode_nxt   = (inq_byte_r == CH_EQ) ? MODE_EQ : MODE_INT;
        pstart_nxt = pos_nxt;
        pcol_nxt   = col_nxt;
        if (pos_nxt != PosMax) pos_nxt = pos_nxt + POS_WIDTH'(1);
        if (col_nxt != CNT_MAX) col_nxt = col_nxt + 16'd1;
      end else begin
        priority case (inq_byte_r)
          CH_PLUS:  k = TK_PLUS;
          CH_MINUS: k = TK_MINUS;
          CH_STAR:  k = TK_STAR;
          CH_SLASH: k = TK_SLASH;
          default:  k = TK_UNKNOWN;
        endcase
        res_nxt[cnt_nxt] = mk_tok(k, pos_nxt, POS_WIDTH'(1), line_nxt, col_nxt);
        cnt_nxt = cnt_nxt + 2'd1;
        if (pos_nxt != PosMax) pos_nxt = pos_nxt + POS_WIDTH'(1);
        if (col_nxt != CNT_MAX) col_nxt = col_nxt + 16'd1;
      end
    end

    if (inq_end_r) begin
      // flush what is left, then the eof token, then back to a fresh source
      if (mode_nxt == MODE_EQ) begin
        res_nxt[cnt_nxt] = mk_tok(TK_EQUAL, pstart_nxt, POS_WIDTH'(1), line_nxt, pcol_nxt);
        cnt_nxt = cnt_nxt + 2'd1;
      end else if (mode_nxt == MODE_INT) begin
        res_nxt[cnt_nxt] = mk_tok(TK_INT, pstart_nxt, pos_nxt - pstart_nxt, line_nxt,
                                  pcol_nxt);
        cnt_nxt = cnt_nxt + 2'd1;
      end
      res_nxt[cnt_nxt] = mk_tok(TK_EOF, pos_nxt, '0, line_nxt, col_nxt);
      cnt_nxt    = cnt_nxt + 2'd1;
      pos_nxt    = '0;
      line_nxt   = 16'd1;
      col_nxt    = 16'd1;
      mode_nxt   = MODE_NONE;
      pstart_nxt = '0;
      pcol_nxt   = 16'd1;
    end
  end

  // control state and lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_v_r  <= 1'b0;
      cnt_r    <= 2'd0;
      rd_r     <= 2'd0;
      pos_r    <= '0;
      line_r   <= 16'd1;
      col_r    <= 16'd1;
      mode_r   <= MODE_NONE;
      pstart_r <= '0;
      pcol_r   <= 16'd1;
    end else begin
      if (in_chan.ready) begin
        inq_v_r <= in_chan.valid;
      end
      if (move) begin
        cnt_r    <= cnt_nxt;
        rd_r     <= 2'd0;
        pos_r    <= pos_nxt;
        line_r   <= line_nxt;
        col_r    <= col_nxt;
        mode_r   <= mode_nxt;
        pstart_r <= pstart_nxt;
        pcol_r   <= pcol_nxt;
      end else if (pop) begin
        cnt_r <= cnt_r - 2'd1;
        rd_r  <= rd_r + 2'd1;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      inq_byte_r    <= in_chan.data_byte;
      inq_present_r <= in_chan.byte_present;
      inq_end_r     <= in_chan.end_of_source;
    end
    if (move) begin
      res_r[0] <= res_nxt[0];
      res_r[1] <= res_nxt[1];
      res_r[2] <= res_nxt[2];
    end
  end

`ifndef SYNTH
  // read pointer never runs past the loaded tokens
  a_buf_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (3'(rd_r) + 3'(cnt_r)) <= 3'd3)
    else $error("result buffer pointer out of range");

  // a new word only loads once the buffer is drained or its last token is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    move |-> ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_chan.ready)))
    else $error("result buffer overwritten with tokens pending");

  // eof is always the final token of its word
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.token_kind == TK_EOF)) |-> out_chan.last_of_run)
    else $error("eof token not marked last");

  // end of source puts the counters back to their start values
  a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (move && inq_end_r) |=> ((pos_r == '0) && (line_r == 16'd1) &&
                             (col_r == 16'd1) && (mode_r == MODE_NONE)))
    else $error("state not restarted after end of source");
`endif

endmodule

`default_nettype wire
